// ----- rtl/pisc_pkg.sv -----
// Package for the peripheral isolation semaphore controller.
// Holds the shared constants, codes and payload types. Depends on nothing.
package pisc_pkg;

  localparam int unsigned NUM_PERIPH_DEF = 178;
  localparam int unsigned ADDR_W         = 12;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CID_W          = 3;
  localparam int unsigned PID_FIELD_W    = 8;
  localparam int unsigned CFG_W          = 24;

  // Register map
  localparam int unsigned OFF_SEC = 'h10;
  localparam int unsigned OFF_CID = 'h100;

  // CID configuration word fields
  localparam int unsigned CFG_FEN_BIT  = 0;
  localparam int unsigned CFG_SEN_BIT  = 1;
  localparam int unsigned CFG_SCID_LSB = 4;
  localparam int unsigned CFG_WL_LSB   = 16;
  localparam int unsigned CFG_WL_W     = 8;

  // Semaphore register read layout
  localparam int unsigned SEM_OWN_LSB = 4;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CID     = 2'd1,
    ST_SECURE  = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    K_INVALID = 3'd0,
    K_SEC_RD  = 3'd1,
    K_SEC_WR  = 3'd2,
    K_CFG_RD  = 3'd3,
    K_CFG_WR  = 3'd4,
    K_SEM_RD  = 3'd5,
    K_SEM_WR  = 3'd6,
    K_QUERY   = 3'd7
  } kind_e;

  typedef enum logic {
    BS_IDLE = 1'b0,
    BS_EXEC = 1'b1
  } bstate_e;

  // Classified request as it travels through the queue
  typedef struct packed {
    kind_e                   kind;
    logic [PID_FIELD_W-1:0]  idx;
    logic [DATA_W-1:0]       wdata;
    logic [CID_W-1:0]        cid;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    status_e           status;
  } rsp_t;

endpackage

// ----- rtl/pisc_if.sv -----
// Handshake channels of the peripheral isolation semaphore controller.
// Request and response interfaces; depend on pisc_pkg for the field widths.
interface pisc_req_if import pisc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [ADDR_W-1:0]      addr;
  logic [DATA_W-1:0]      wdata;
  logic [CID_W-1:0]       req_cid;
  logic [PID_FIELD_W-1:0] periph_id;

  modport source (output valid, op, addr, wdata, req_cid, periph_id, input ready);
  modport sink   (input valid, op, addr, wdata, req_cid, periph_id, output ready);
endinterface

interface pisc_rsp_if import pisc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic [1:0]        status;

  modport source (output valid, rdata, status, input ready);
  modport sink   (input valid, rdata, status, output ready);
endinterface

// ----- rtl/peripheral_isolation_semaphore_ctrl.sv -----
// Peripheral isolation controller register file with hardware semaphores.
// Top level: front end, command queue and back end. Depends on pisc_pkg,
// pisc_req_if, pisc_rsp_if, pisc_front, pisc_queue and pisc_back.
//
// Usage:
//   req_i carries one request (op, addr, wdata, req_cid, periph_id): a
//   register read, a register write or an access query for a peripheral.
//   rsp_o returns exactly one response (rdata, status) per request, in order.
//   Both are valid/ready channels; a request is taken when valid and ready
//   are high at a rising edge of clk_i.
// Timing:
//   The front end decodes the address and op and pushes a command into a
//   two-entry queue, so requests are taken while a response still waits.
//   The back end registers the CID config and owner memory reads when it
//   pops a command, executes the command in its exec state and registers
//   the result in the response register. It pops only from its idle state,
//   so it does not start a new command while one is executing.
// Reset:
//   rst_ni clears secure words, marks every CID config entry as zero and
//   every semaphore as free, and empties the queue and response register.
//   No clearing pass is needed; the block is ready as soon as reset is released.
// Back pressure:
//   While rsp_o.ready is low the response is held; the back end stops
//   popping and the queue fills, after which req_i.ready drops.
module peripheral_isolation_semaphore_ctrl import pisc_pkg::*; #(
  parameter int unsigned NUM_PERIPH = NUM_PERIPH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pisc_req_if.sink    req_i,
  pisc_rsp_if.source  rsp_o
);

  logic  push;
  logic  full;
  logic  avail;
  logic  pop;
  item_t push_item;
  item_t head_item;

  // Decode requests into commands
  pisc_front #(
    .NUM_PERIPH (NUM_PERIPH)
  ) u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // Decouple decode from execution
  pisc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .avail_o (avail),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  // Execute against the register file and semaphores
  pisc_back #(
    .NUM_PERIPH (NUM_PERIPH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .item_i  (head_item),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

// ----- rtl/pisc_front.sv -----
// Request front end: decodes each request into a command for the back end.
// Depends on pisc_pkg and pisc_req_if.
module pisc_front import pisc_pkg::*; #(
  parameter int unsigned NUM_PERIPH = NUM_PERIPH_DEF
) (
  pisc_req_if.sink req_i,
  input  logic     full_i,
  output logic     push_o,
  output item_t    item_o
);

  localparam int unsigned SEC_WORDS = (NUM_PERIPH + 31) / 32;
  localparam logic [ADDR_W:0] SEC_END = (ADDR_W + 1)'(OFF_SEC + 4 * SEC_WORDS);
  localparam logic [ADDR_W:0] CID_END = (ADDR_W + 1)'(OFF_CID + 8 * NUM_PERIPH);

  logic [ADDR_W-1:0] sec_off;
  logic [ADDR_W-1:0] cid_off;
  logic              in_sec;
  logic              in_cid;
  logic              is_wr;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  assign sec_off = req_i.addr - ADDR_W'(OFF_SEC);
  assign cid_off = req_i.addr - ADDR_W'(OFF_CID);
  assign in_sec  = (req_i.addr >= ADDR_W'(OFF_SEC)) && ({1'b0, req_i.addr} < SEC_END);
  assign in_cid  = (req_i.addr >= ADDR_W'(OFF_CID)) && ({1'b0, req_i.addr} < CID_END);
  assign is_wr   = (op_e'(req_i.op) == OP_WRITE);

  always_comb begin
    item_o       = '0;
    item_o.kind  = K_INVALID;
    item_o.wdata = req_i.wdata;
    item_o.cid   = req_i.req_cid;
    unique case (op_e'(req_i.op))
      OP_QUERY: begin
        // Out-of-range peripheral ids stay invalid
        if ({1'b0, req_i.periph_id} < (PID_FIELD_W + 1)'(NUM_PERIPH)) begin
          item_o.kind = K_QUERY;
          item_o.idx  = req_i.periph_id;
        end
      end
      OP_READ, OP_WRITE: begin
        if (req_i.addr[1:0] == 2'b00) begin
          if (in_sec) begin
            item_o.kind = is_wr ? K_SEC_WR : K_SEC_RD;
            item_o.idx  = sec_off[PID_FIELD_W+1:2];
          end else if (in_cid) begin
            item_o.idx = cid_off[PID_FIELD_W+2:3];
            if (!req_i.addr[2]) begin
              item_o.kind = is_wr ? K_CFG_WR : K_CFG_RD;
            end else begin
              item_o.kind = is_wr ? K_SEM_WR : K_SEM_RD;
            end
          end
        end
      end
      default: begin
        item_o.kind = K_INVALID;
      end
    endcase
  end

endmodule

// ----- rtl/pisc_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on pisc_pkg.
module pisc_queue import pisc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  avail_o,
  input  logic  pop_i,
  output item_t item_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

// ----- rtl/pisc_back.sv -----
// Back end: executes queued commands against the secure words, CID config
// memory and semaphores, and holds the response register. Depends on pisc_pkg.
module pisc_back import pisc_pkg::*; #(
  parameter int unsigned NUM_PERIPH = NUM_PERIPH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  item_t       item_i,
  output logic        pop_o,
  pisc_rsp_if.source  rsp_o
);

  localparam int unsigned SEC_WORDS = (NUM_PERIPH + 31) / 32;
  localparam int unsigned SEC_IW    = (SEC_WORDS > 1) ? $clog2(SEC_WORDS) : 1;
  localparam int unsigned PID_W     = (NUM_PERIPH > 1) ? $clog2(NUM_PERIPH) : 1;

  bstate_e state_q, state_d;
  item_t   cur_q;
  rsp_t    out_q, res;
  logic    out_vld_q;
  logic    out_free;

  logic [CFG_W-1:0]  cfg_mem [NUM_PERIPH];
  logic [CFG_W-1:0]  cfg_rd_q;
  logic [CID_W-1:0]  own_mem [NUM_PERIPH];
  logic [CID_W-1:0]  own_rd_q;
  logic [NUM_PERIPH-1:0] cfg_vld_q;
  logic [NUM_PERIPH-1:0] held_q;
  logic [DATA_W-1:0] sec_q [SEC_WORDS];

  logic [PID_W-1:0]    n;
  logic [PID_W-1:0]    rd_n;
  logic [SEC_IW-1:0]   k;
  logic [SEC_IW-1:0]   sk;
  logic [CFG_W-1:0]    cfg;
  logic [CFG_WL_W-1:0] wl;
  logic [CID_W-1:0]    scid;
  logic [CID_W-1:0]    owner;
  logic                held;
  logic                sbit;
  logic                sec_we;
  logic                cfg_we;
  logic                take;
  logic                release_sem;

  assign out_free = !out_vld_q || rsp_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: if (avail_i && out_free) state_d = BS_EXEC;
      BS_EXEC: state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o = 1'b0;
    unique case (state_q)
      BS_IDLE: pop_o = avail_i && out_free;
      BS_EXEC: pop_o = 1'b0;
      default: pop_o = 1'b0;
    endcase
  end

  assign n     = cur_q.idx[PID_W-1:0];
  assign rd_n  = item_i.idx[PID_W-1:0];
  assign k     = cur_q.idx[SEC_IW-1:0];
  assign sk    = cur_q.idx[5 +: SEC_IW];
  assign sbit  = sec_q[sk][cur_q.idx[4:0]];
  assign cfg   = cfg_vld_q[n] ? cfg_rd_q : '0;
  assign held  = held_q[n];
  // Owner reads as zero whenever the semaphore is free
  assign owner = held ? own_rd_q : '0;
  assign scid  = cfg[CFG_SCID_LSB +: CID_W];
  assign wl    = cfg[CFG_WL_LSB +: CFG_WL_W];

  always_comb begin
    res         = '0;
    res.status  = ST_OK;
    sec_we      = 1'b0;
    cfg_we      = 1'b0;
    take        = 1'b0;
    release_sem = 1'b0;
    unique case (cur_q.kind)
      K_SEC_RD: res.rdata = sec_q[k];
      K_SEC_WR: sec_we = 1'b1;
      K_CFG_RD: res.rdata = DATA_W'(cfg);
      K_CFG_WR: cfg_we = 1'b1;
      K_SEM_RD: begin
        res.rdata[0]                   = held;
        res.rdata[SEM_OWN_LSB +: CID_W] = owner;
      end
      K_SEM_WR: begin
        if (cur_q.wdata[0]) begin
          if (held) begin
            res.status = (owner == cur_q.cid) ? ST_OK : ST_CID;
          end else if (wl[cur_q.cid]) begin
            take = 1'b1;
          end else begin
            res.status = ST_CID;
          end
        end else if (held) begin
          if (owner != cur_q.cid) begin
            res.status = ST_CID;
          end else begin
            release_sem = 1'b1;
          end
        end
      end
      K_QUERY: begin
        if (!cfg[CFG_SEN_BIT] && cfg[CFG_FEN_BIT] && scid != '0 && scid != cur_q.cid) begin
          res.status = ST_CID;
        end else if (sbit) begin
          res.status = ST_SECURE;
        end
      end
      default: res.status = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      out_vld_q <= 1'b0;
      cfg_vld_q <= '0;
      held_q    <= '0;
      for (int i = 0; i < SEC_WORDS; i++) sec_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BS_EXEC) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == BS_EXEC) begin
        if (sec_we)      sec_q[k]     <= cur_q.wdata;
        if (cfg_we)      cfg_vld_q[n] <= 1'b1;
        if (take)        held_q[n]    <= 1'b1;
        if (release_sem) held_q[n]    <= 1'b0;
      end
    end
  end

  // Payload registers and memories
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q    <= item_i;
      cfg_rd_q <= cfg_mem[rd_n];
      own_rd_q <= own_mem[rd_n];
    end
    if (state_q == BS_EXEC) begin
      out_q <= res;
      if (cfg_we) cfg_mem[n] <= cur_q.wdata[CFG_W-1:0];
      if (take)   own_mem[n] <= cur_q.cid;
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.rdata  = out_q.rdata;
  assign rsp_o.status = out_q.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_EXEC) |-> !out_vld_q)
    else $error("result computed while response register still occupied");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_EXEC) |=> out_vld_q)
    else $error("executed command produced no response");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BS_EXEC)
    else $error("popped command not executed");

endmodule

// ----- sim/pisc_reply_checker.sv -----
// Reply checker for the peripheral isolation semaphore controller testbench.
// Mirrors the secure words, CID configs and semaphores, predicts every reply and
// compares it in order. Depends on pisc_pkg, pisc_req_if and pisc_rsp_if.
module pisc_reply_checker import pisc_pkg::*; #(
  parameter int unsigned NUM_PERIPH = NUM_PERIPH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pisc_req_if         req_mon,
  pisc_rsp_if         rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned requests_o,
  output int unsigned verdicts_o [4]
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEC_WORDS = (NUM_PERIPH + 31) / 32;
  localparam int unsigned CFG_STRIDE = 8;

  logic [DATA_W-1:0] secure_q [SEC_WORDS];
  logic [CFG_W-1:0]  cfg_q    [NUM_PERIPH];
  logic              held_q   [NUM_PERIPH];
  logic [CID_W-1:0]  owner_q  [NUM_PERIPH];
  rsp_t              awaited_replies [$];
  int unsigned       fails;

  // Work out the reply to one request and apply its side effects to the mirror.
  task automatic predict_reply(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata, input logic [CID_W-1:0] cid,
                               input logic [PID_FIELD_W-1:0] pid, output rsp_t reply);
    int unsigned      n;
    logic [CFG_W-1:0] cfg;
    logic [CID_W-1:0] scid;
    reply.rdata  = '0;
    reply.status = ST_INVALID;
    if (op == OP_QUERY) begin
      if (pid < NUM_PERIPH) begin
        cfg  = cfg_q[pid];
        scid = cfg[CFG_SCID_LSB +: CID_W];
        // semaphore mode bypasses the static CID filter
        if (!cfg[CFG_SEN_BIT] && cfg[CFG_FEN_BIT] && scid != '0 && scid != cid)
          reply.status = ST_CID;
        else if (secure_q[pid >> 5][pid[4:0]])
          reply.status = ST_SECURE;
        else
          reply.status = ST_OK;
      end
    end else if ((op == OP_READ || op == OP_WRITE) && addr[1:0] == 2'b00) begin
      if (addr >= OFF_SEC && addr < OFF_SEC + 4 * SEC_WORDS) begin
        n = (addr - OFF_SEC) >> 2;
        if (op == OP_READ) reply.rdata = secure_q[n];
        else secure_q[n] = wdata;
        reply.status = ST_OK;
      end else if (addr >= OFF_CID && addr < OFF_CID + CFG_STRIDE * NUM_PERIPH) begin
        n = (addr - OFF_CID) / CFG_STRIDE;
        if (!addr[2]) begin
          if (op == OP_READ) reply.rdata = DATA_W'(cfg_q[n]);
          else cfg_q[n] = wdata[CFG_W-1:0];
          reply.status = ST_OK;
        end else if (op == OP_READ) begin
          reply.rdata[0]                       = held_q[n];
          reply.rdata[SEM_OWN_LSB +: CID_W]    = owner_q[n];
          reply.status                         = ST_OK;
        end else if (wdata[0]) begin
          // take: succeeds for the current owner, or if free and whitelisted
          if (held_q[n]) begin
            reply.status = (owner_q[n] == cid) ? ST_OK : ST_CID;
          end else if (!cfg_q[n][CFG_WL_LSB + cid]) begin
            reply.status = ST_CID;
          end else begin
            held_q[n]    = 1'b1;
            owner_q[n]   = cid;
            reply.status = ST_OK;
          end
        end else begin
          // release: only the owner frees it, a free one is left alone
          if (!held_q[n]) begin
            reply.status = ST_OK;
          end else if (owner_q[n] != cid) begin
            reply.status = ST_CID;
          end else begin
            held_q[n]    = 1'b0;
            owner_q[n]   = '0;
            reply.status = ST_OK;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t fresh;
    if (!rst_ni) begin
      foreach (secure_q[i]) secure_q[i] = '0;
      foreach (cfg_q[i]) begin
        cfg_q[i]   = '0;
        held_q[i]  = 1'b0;
        owner_q[i] = '0;
      end
      awaited_replies.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      requests_o   <= 0;
      foreach (verdicts_o[i]) verdicts_o[i] <= 0;
    end else begin
      // replies first: one taken this edge belongs to an earlier request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          fails++;
          $error("reply with no request outstanding: rdata %h status %0d",
                 rsp_mon.rdata, rsp_mon.status);
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_mon.rdata !== want.rdata) begin
            fails++;
            $error("rdata: expected %h, got %h", want.rdata, rsp_mon.rdata);
          end
          if (rsp_mon.status !== want.status) begin
            fails++;
            $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
          end
          verdicts_o[want.status] <= verdicts_o[want.status] + 1;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_reply(req_mon.op, req_mon.addr, req_mon.wdata, req_mon.req_cid,
                      req_mon.periph_id, fresh);
        awaited_replies.push_back(fresh);
        requests_o <= requests_o + 1;
      end
      fail_count_o <= fails;
      pending_o    <= awaited_replies.size();
    end
  end

endmodule

// ----- sim/peripheral_isolation_semaphore_ctrl_tb.sv -----
// Top of the peripheral isolation semaphore controller testbench.
// Drives requests and reply back-pressure, and gives the verdict from the checker.
// Depends on pisc_pkg, pisc_req_if, pisc_rsp_if, pisc_reply_checker and the block.
module peripheral_isolation_semaphore_ctrl_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pisc_pkg::*;

  localparam int unsigned NUM_PERIPH   = NUM_PERIPH_DEF;
  localparam int unsigned SEC_WORDS    = (NUM_PERIPH + 31) / 32;
  localparam int unsigned SEM_OFS      = 4;
  localparam int unsigned CFG_STRIDE   = 8;
  localparam logic [1:0]  OP_UNDEF     = 2'd3;   // no operation decodes to this
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned HOLD_AFTER   = 400;    // requests sent before the long stall
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned QUIET_LIMIT  = 2000;   // cycles with no handshake at all

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_count;
  logic        long_hold_done;

  int unsigned failures;
  int unsigned pending;
  int unsigned requests;
  int unsigned verdicts [4];

  pisc_req_if req_ch ();
  pisc_rsp_if rsp_ch ();

  peripheral_isolation_semaphore_ctrl #(.NUM_PERIPH(NUM_PERIPH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  pisc_reply_checker #(.NUM_PERIPH(NUM_PERIPH)) reply_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (failures),
    .pending_o    (pending),
    .requests_o   (requests),
    .verdicts_o   (verdicts)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Register map helpers: secure word k, CID config and semaphore of peripheral n.
  function automatic logic [ADDR_W-1:0] sec_addr(int unsigned k);
    return ADDR_W'(OFF_SEC + 4 * k);
  endfunction

  function automatic logic [ADDR_W-1:0] cfg_addr(int unsigned n);
    return ADDR_W'(OFF_CID + CFG_STRIDE * n);
  endfunction

  function automatic logic [ADDR_W-1:0] sem_addr(int unsigned n);
    return cfg_addr(n) + ADDR_W'(SEM_OFS);
  endfunction

  // Mostly a small hot set at both ends of the map, so that semaphores collide,
  // otherwise any peripheral.
  function automatic int unsigned pick_periph();
    int unsigned k;
    if ($urandom_range(3) == 0) return $urandom_range(NUM_PERIPH - 1);
    k = $urandom_range(7);
    return (k < 4) ? k : NUM_PERIPH - 8 + k;
  endfunction

  // Offer one request from a falling edge and hold it until the block takes it.
  // Idle cycles go in front of it at the sender's current rate.
  task automatic send_request(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              input logic [CID_W-1:0] cid,
                              input logic [PID_FIELD_W-1:0] pid);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.addr      <= addr;
    req_ch.wdata     <= wdata;
    req_ch.req_cid   <= cid;
    req_ch.periph_id <= pid;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_count++;
  endtask

  // Reply side: random ready at the current rate, plus one long stall while the
  // sender keeps offering, so the command queue fills and request ready drops.
  initial begin : reply_taker
    rsp_ch.ready   = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && sent_count >= HOLD_AFTER) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Abort if neither channel completes a handshake for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned      pick;
    int unsigned      n;
    logic [1:0]       op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [CID_W-1:0] cid;
    logic [PID_FIELD_W-1:0] pid;

    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_READ;
    req_ch.addr      = '0;
    req_ch.wdata     = '0;
    req_ch.req_cid   = '0;
    req_ch.periph_id = '0;
    sent_count       = 0;
    send_idle_pct    = 25;
    recv_idle_pct    = 69;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: map edges, bad addresses and op, config masking, the semaphore
    // take/release rules and each query verdict.
    send_request(OP_READ,  sec_addr(0), '0, '0, '0);
    send_request(OP_WRITE, sec_addr(0), 32'hFFFF_FFFF, '0, '0);
    // peripheral NUM_PERIPH-1 sits at bit 17 of the last secure word
    send_request(OP_WRITE, sec_addr(SEC_WORDS - 1), 32'h0002_0000, '0, '0);
    send_request(OP_READ,  sec_addr(SEC_WORDS - 1), '0, '0, '0);
    send_request(OP_READ,  sec_addr(SEC_WORDS), '0, '0, '0);       // just past the words
    send_request(OP_READ,  ADDR_W'(OFF_SEC - 4), '0, '0, '0);      // just below them
    send_request(OP_WRITE, cfg_addr(0) + ADDR_W'(1), '1, '0, '0);  // unaligned
    send_request(OP_UNDEF, sec_addr(0), '1, '0, '0);
    // upper byte of a config write is dropped
    send_request(OP_WRITE, cfg_addr(0), 32'hFFFF_FFFF, '0, '0);
    send_request(OP_READ,  cfg_addr(0), '0, '0, '0);
    send_request(OP_READ,  cfg_addr(NUM_PERIPH), '0, '0, '0);
    send_request(OP_READ,  sem_addr(NUM_PERIPH - 1), '0, '0, '0);
    send_request(OP_READ,  ADDR_W'(4095), '0, '0, '0);
    // whitelist only CID 2 on peripheral 1, then exercise its semaphore
    send_request(OP_WRITE, cfg_addr(1), 32'h1 << (CFG_WL_LSB + 2), '0, '0);
    send_request(OP_WRITE, sem_addr(1), 32'hFFFF_FFF1, 3'd2, '0);  // take, junk bits
    send_request(OP_WRITE, sem_addr(1), 32'h1, 3'd2, '0);          // owner takes again
    send_request(OP_WRITE, sem_addr(1), 32'h1, 3'd3, '0);          // held by another
    send_request(OP_WRITE, sem_addr(1), 32'h0, 3'd3, '0);          // release by non-owner
    send_request(OP_READ,  sem_addr(1), '0, '0, '0);
    send_request(OP_WRITE, sem_addr(1), 32'hFFFF_FFFE, 3'd2, '0);  // owner releases
    send_request(OP_WRITE, sem_addr(1), 32'h0, 3'd2, '0);          // release when free
    send_request(OP_WRITE, sem_addr(1), 32'h1, 3'd5, '0);          // not whitelisted
    send_request(OP_QUERY, '0, '0, '0, PID_FIELD_W'(255));
    send_request(OP_QUERY, '0, '0, '0, PID_FIELD_W'(NUM_PERIPH));
    send_request(OP_QUERY, '0, '0, '0, PID_FIELD_W'(NUM_PERIPH - 1));
    // filter on, static CID 5: a stranger is refused, the owner sees the secure bit
    send_request(OP_WRITE, cfg_addr(2), 32'h51, '0, '0);
    send_request(OP_QUERY, '0, '0, 3'd3, PID_FIELD_W'(2));
    send_request(OP_QUERY, '0, '0, 3'd5, PID_FIELD_W'(2));
    // semaphore mode skips the CID check
    send_request(OP_WRITE, cfg_addr(2), 32'h53, '0, '0);
    send_request(OP_QUERY, '0, '0, 3'd3, PID_FIELD_W'(2));

    // Random part in three pacing phases: slow receiver, slow sender, flat out.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 25;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n     = pick_periph();
      cid   = CID_W'($urandom_range(7));
      wdata = $urandom();
      pid   = PID_FIELD_W'($urandom_range(255));
      addr  = ADDR_W'($urandom_range(4095));
      pick  = $urandom_range(99);
      if (pick < 28) begin
        // semaphore traffic from a couple of favoured CIDs so releases match owners
        op   = OP_WRITE;
        addr = sem_addr(n);
        if ($urandom_range(1)) cid = CID_W'($urandom_range(2, 3));
      end else if (pick < 40) begin
        op   = OP_WRITE;
        addr = cfg_addr(n);
      end else if (pick < 46) begin
        op   = OP_WRITE;
        addr = sec_addr($urandom_range(SEC_WORDS - 1));
      end else if (pick < 62) begin
        op = OP_READ;
        case ($urandom_range(2))
          0: addr = sec_addr(n >> 5);
          1: addr = cfg_addr(n);
          default: addr = sem_addr(n);
        endcase
      end else if (pick < 88) begin
        op = OP_QUERY;
        if ($urandom_range(9) != 0) pid = PID_FIELD_W'(n);
      end else begin
        // noise: any op, any offset
        op = 2'($urandom_range(3));
      end
      send_request(op, addr, wdata, cid, pid);
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every reply, then wait on for any stray one.
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d requests over three pacing phases and a %0d-cycle reply stall.",
             requests, HOLD_CYCLES);
    $display("Replies by status: ok %0d, cid mismatch %0d, secure-only %0d, invalid %0d.",
             verdicts[ST_OK], verdicts[ST_CID], verdicts[ST_SECURE], verdicts[ST_INVALID]);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- peripheral_isolation_semaphore_ctrl.f -----
rtl/pisc_pkg.sv
rtl/pisc_if.sv
rtl/pisc_front.sv
rtl/pisc_queue.sv
rtl/pisc_back.sv
rtl/peripheral_isolation_semaphore_ctrl.sv
sim/pisc_reply_checker.sv
sim/peripheral_isolation_semaphore_ctrl_tb.sv
